@@ rtl/tbwlc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwlc_pkg
// shared widths, register indexes and controller command/status types
// ----------------------------------------------------------------------------
package tbwlc_pkg;

   localparam int NOISE_BITS = 16;
   localparam int COUNT_BITS = 32;
   localparam int NOISE_FRAC = 12;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DECAY   = 3'd0,
      CSR_DRIFT   = 3'd1,
      CSR_NOISE   = 3'd2,
      CSR_PULL    = 3'd3,
      CSR_PREFAC  = 3'd4,
      CSR_INVCON  = 3'd5,
      CSR_STIFF   = 3'd6,
      CSR_LIMIT   = 3'd7
   } csr_idx_type;

   // datapath operation selected by the controller; most drive the shared multiplier
   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_LOAD   = 4'd1,  // capture noise, compute extension
      OP_FORCE  = 4'd2,  // stiffness * trap
      OP_RATIO  = 4'd3,  // ext * inv_contour
      OP_DIVST  = 4'd4,  // start divider
      OP_DIVIT  = 4'd5,  // one divider step
      OP_SQUARE = 4'd6,  // w * w, bracket sum
      OP_CHAIN  = 4'd7,  // prefactor * s
      OP_DECAY  = 4'd8,  // decay * trap
      OP_DRIFT  = 4'd9,  // drift * wlc
      OP_NOISE  = 4'd10, // noise gain * noise
      OP_COMMIT = 4'd11  // publish result and update state
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic clip;
   } ctl_stat_type;

endpackage

@@ rtl/tbwlc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwlc_ctrl
// sequencer stepping the shared datapath through one time step
// ----------------------------------------------------------------------------
module tbwlc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   out_busy,
   input  tbwlc_pkg::ctl_stat_type stat,
   output tbwlc_pkg::ctl_cmd_type  cmd
);
   import tbwlc_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_FORCE  = 12'b000000000010,
      S_RATIO  = 12'b000000000100,
      S_DIVST  = 12'b000000001000,
      S_DIVIT  = 12'b000000010000,
      S_SQUARE = 12'b000000100000,
      S_CHAIN  = 12'b000001000000,
      S_DECAY  = 12'b000010000000,
      S_DRIFT  = 12'b000100000000,
      S_NOISE  = 12'b001000000000,
      S_WAIT   = 12'b010000000000,
      S_COMMIT = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_FORCE;
            end
         end
         S_FORCE: begin
            cmd.op = OP_FORCE;  state_in = S_RATIO;
         end
         S_RATIO: begin
            cmd.op = OP_RATIO;  state_in = S_DIVST;
         end
         S_DIVST: begin
            cmd.op = OP_DIVST;
            state_in = stat.clip ? S_DECAY : S_DIVIT;
         end
         S_DIVIT: begin
            cmd.op = OP_DIVIT;
            if (stat.div_done) state_in = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.op = OP_SQUARE; state_in = S_CHAIN;
         end
         S_CHAIN: begin
            cmd.op = OP_CHAIN;  state_in = S_DECAY;
         end
         S_DECAY: begin
            cmd.op = OP_DECAY;  state_in = S_DRIFT;
         end
         S_DRIFT: begin
            cmd.op = OP_DRIFT;  state_in = S_NOISE;
         end
         S_NOISE: begin
            cmd.op = OP_NOISE;  state_in = S_WAIT;
         end
         S_WAIT: begin
            if (!out_busy) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.op = OP_COMMIT; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/tbwlc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwlc_datapath
// state registers, one shared multiplier, restoring divider, result register
// ----------------------------------------------------------------------------
module tbwlc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [tbwlc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [tbwlc_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic signed [tbwlc_pkg::NOISE_BITS-1:0] req_noise_sample,
   input  tbwlc_pkg::ctl_cmd_type             cmd,
   output tbwlc_pkg::ctl_stat_type            stat,
   output logic                              out_busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_step_index,
   output logic signed [31:0]                rsp_trap_position,
   output logic signed [31:0]                rsp_pipette_position,
   output logic signed [31:0]                rsp_extension,
   output logic signed [31:0]                rsp_trap_force,
   output logic signed [31:0]                rsp_chain_force,
   output logic                              rsp_chain_saturated,
   output logic                              rsp_last
);
   import tbwlc_pkg::*;

   localparam logic signed [63:0] ONE32 = 64'sd1 <<< 32;
   localparam logic signed [63:0] MAX32 = 64'sd2147483647;
   localparam logic signed [63:0] MIN32 = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'(MAX32))      r = 32'sh7FFFFFFF;
      else if (v < 66'(MIN32)) r = 32'sh80000000;
      else                     r = v[31:0];
      return r;
   endfunction

   // configuration
   logic [30:0] decay_ff, drift_ff, noise_g_ff, pull_ff, prefac_ff, stiff_ff, limit_ff;
   logic [31:0] invcon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff   <= 31'd1073741824;
         drift_ff   <= '0;
         noise_g_ff <= '0;
         pull_ff    <= '0;
         prefac_ff  <= 31'd5387;
         invcon_ff  <= 32'd12632470;
         stiff_ff   <= '0;
         limit_ff   <= 31'd1966080;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_DECAY:  decay_ff   <= csr_data[30:0];
            CSR_DRIFT:  drift_ff   <= csr_data[30:0];
            CSR_NOISE:  noise_g_ff <= csr_data[30:0];
            CSR_PULL:   pull_ff    <= csr_data[30:0];
            CSR_PREFAC: prefac_ff  <= csr_data[30:0];
            CSR_INVCON: invcon_ff  <= csr_data;
            CSR_STIFF:  stiff_ff   <= csr_data[30:0];
            CSR_LIMIT:  limit_ff   <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // run state
   logic signed [31:0] trap_ff, pipe_ff;
   logic [COUNT_BITS-1:0] count_ff;

   // working registers
   logic signed [NOISE_BITS-1:0] noise_ff;
   logic signed [31:0] ext_ff, force_ff, wlc_ff;
   logic signed [63:0] r32_ff;
   logic clip_ff;
   logic [47:0] u_ff;         // divisor 1 - r, up to 2^32 + 2^47 for large negative r
   logic [55:0] rem_ff;
   logic [55:0] quo_ff;
   logic [5:0]  div_cnt_ff;
   logic signed [65:0] acc_ff;

   // shared signed multiplier, 34 x 34
   logic signed [33:0] ma, mb;
   logic signed [67:0] mp;
   assign mp = ma * mb;

   logic [32:0] wsq;
   assign wsq = (quo_ff >= 56'(64'd1 << 32)) ? 33'h1_0000_0000 : 33'd0;

   always_comb begin
      ma = '0; mb = '0;
      case (cmd.op)
         OP_FORCE: begin ma = 34'(signed'({1'b0, stiff_ff}));  mb = 34'(trap_ff); end
         OP_RATIO: begin ma = 34'(ext_ff); mb = 34'(signed'({1'b0, invcon_ff})); end
         OP_SQUARE: begin
            ma = 34'(signed'({2'b0, quo_ff[31:0]}));
            mb = 34'(signed'({2'b0, quo_ff[31:0]}));
         end
         OP_CHAIN: begin ma = 34'(signed'({1'b0, prefac_ff})); mb = acc_ff[33:0]; end
         OP_DECAY: begin ma = 34'(signed'({1'b0, decay_ff}));  mb = 34'(trap_ff); end
         OP_DRIFT: begin ma = 34'(signed'({1'b0, drift_ff}));  mb = 34'(wlc_ff); end
         OP_NOISE: begin ma = 34'(signed'({1'b0, noise_g_ff})); mb = 34'(noise_ff); end
         default: ;
      endcase
   end

   logic signed [63:0] r_next;
   assign r_next = 64'(mp >>> 16);

   // bracket sum: term + r>>16 - 1/4, clamped to +-2^32
   logic signed [65:0] s_raw, s_cl;
   always_comb begin
      s_raw = 66'(signed'({1'b0, (quo_ff >= 56'(64'd1 << 32)) ? 64'(wsq)
                                                              : 64'(mp[63:32])}))
            + 66'(r32_ff >>> 16) - 66'sd16384;
      if (s_raw > 66'(ONE32))       s_cl = 66'(ONE32);
      else if (s_raw < -66'(ONE32)) s_cl = -66'(ONE32);
      else                          s_cl = s_raw;
   end

   logic [56:0] rem_sh;
   logic [56:0] rem_sub;
   assign rem_sh  = {rem_ff, quo_ff[55]};
   assign rem_sub = rem_sh - 57'(u_ff);

   logic rsp_valid_ff;
   logic [31:0] o_idx_ff;
   logic signed [31:0] o_trap_ff, o_pipe_ff, o_ext_ff, o_force_ff, o_wlc_ff;
   logic o_clip_ff, o_last_ff;
   logic last_w;
   assign last_w = (force_ff >= signed'({1'b0, limit_ff}));

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            noise_ff <= req_noise_sample;
            ext_ff   <= sat32(66'(pipe_ff) - 66'(trap_ff));
         end
         OP_FORCE: force_ff <= sat32(66'(mp >>> 16));
         OP_RATIO: r32_ff   <= r_next;
         OP_DIVST: begin
            clip_ff    <= (r32_ff >= ONE32);
            u_ff       <= 48'(ONE32 - r32_ff);
            rem_ff     <= '0;
            quo_ff     <= 56'(64'd1 << 55);
            div_cnt_ff <= '0;
            if (r32_ff >= ONE32) begin
               wlc_ff <= 32'sh7FFFFFFF;
            end
         end
         OP_DIVIT: begin
            // restoring division, one quotient bit per cycle
            if (!rem_sub[56]) rem_ff <= rem_sub[55:0];
            else              rem_ff <= rem_sh[55:0];
            quo_ff     <= {quo_ff[54:0], ~rem_sub[56]};
            div_cnt_ff <= div_cnt_ff + 6'd1;
         end
         OP_SQUARE: acc_ff <= s_cl;
         OP_CHAIN:  wlc_ff <= sat32(66'(mp >>> 16));
         OP_DECAY:  acc_ff <= 66'(mp >>> 30);
         OP_DRIFT:  acc_ff <= acc_ff + 66'(mp >>> 16);
         OP_NOISE:  acc_ff <= acc_ff + 66'(mp >>> NOISE_FRAC);
         default: ;
      endcase
   end

   assign stat.div_done = (div_cnt_ff == 6'd55);
   assign stat.clip     = (r32_ff >= ONE32);

   always_ff @(posedge clock) begin
      if (reset) begin
         trap_ff <= '0; pipe_ff <= '0; count_ff <= '0;
      end else if (cmd.op == OP_COMMIT) begin
         if (last_w) begin
            trap_ff <= '0; pipe_ff <= '0; count_ff <= '0;
         end else begin
            trap_ff  <= sat32(acc_ff);
            pipe_ff  <= sat32(66'(pipe_ff) + 66'(signed'({1'b0, pull_ff})));
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.op == OP_COMMIT) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_COMMIT) begin
         o_idx_ff   <= 32'(count_ff);
         o_trap_ff  <= trap_ff;
         o_pipe_ff  <= pipe_ff;
         o_ext_ff   <= ext_ff;
         o_force_ff <= force_ff;
         o_wlc_ff   <= wlc_ff;
         o_clip_ff  <= clip_ff;
         o_last_ff  <= last_w;
      end
   end

   assign out_busy             = rsp_valid_ff && rsp_stall;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_step_index       = o_idx_ff;
   assign rsp_trap_position    = o_trap_ff;
   assign rsp_pipette_position = o_pipe_ff;
   assign rsp_extension        = o_ext_ff;
   assign rsp_trap_force       = o_force_ff;
   assign rsp_chain_force      = o_wlc_ff;
   assign rsp_chain_saturated  = o_clip_ff;
   assign rsp_last             = o_last_ff;

endmodule

@@ rtl/trapped_bead_wlc_langevin_step_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapped_bead_wlc_langevin_step_unit
// one euler-maruyama step of a trapped bead tethered by a worm-like chain
// ----------------------------------------------------------------------------
// Each request carries one noise sample and yields one response with the
// step index, both bead positions, extension, trap force and the
// Marko-Siggia chain force, then advances the positions. A request runs
// through the 56-step restoring divider that forms 1/(2(1-r)), skipped
// with the square and chain steps when the extension reaches the contour
// length, and waits while the previous response is still held. The
// single shared multiplier is used for all products. One request is in work
// at a time; the response register lets the next request start while a
// response still waits. The last flag resets positions and step count.
module trapped_bead_wlc_langevin_step_unit (
   input  logic clock,
   input  logic reset,
   input  logic                              csr_write,
   input  logic [tbwlc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [tbwlc_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tbwlc_pkg::NOISE_BITS-1:0] req_noise_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_step_index,
   output logic signed [31:0]                rsp_trap_position,
   output logic signed [31:0]                rsp_pipette_position,
   output logic signed [31:0]                rsp_extension,
   output logic signed [31:0]                rsp_trap_force,
   output logic signed [31:0]                rsp_chain_force,
   output logic                              rsp_chain_saturated,
   output logic                              rsp_last
);
   import tbwlc_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   logic         out_busy;

   // sequencer
   tbwlc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .out_busy(out_busy), .stat(stat), .cmd(cmd)
   );

   // arithmetic, state and response register
   tbwlc_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_noise_sample(req_noise_sample),
      .cmd(cmd), .stat(stat), .out_busy(out_busy),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_step_index(rsp_step_index),
      .rsp_trap_position(rsp_trap_position),
      .rsp_pipette_position(rsp_pipette_position),
      .rsp_extension(rsp_extension),
      .rsp_trap_force(rsp_trap_force),
      .rsp_chain_force(rsp_chain_force),
      .rsp_chain_saturated(rsp_chain_saturated),
      .rsp_last(rsp_last)
   );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the trapped-bead worm-like-chain step unit
// ----------------------------------------------------------------------------
// Sends noise samples through the request channel and checks every response
// against a bit-accurate model of the fixed-point Langevin step. Covers
// register extremes, chain saturation, chain term cap, the force-limit
// restart, position saturation, long response back-pressure and randomized
// register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import tbwlc_pkg::*;

   localparam longint ONE32 = 64'sd4294967296;
   localparam longint IMAX = 64'sd2147483647;
   localparam longint IMIN = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [31:0] step_index;
      logic [31:0] trap_position;
      logic [31:0] pipette_position;
      logic [31:0] extension;
      logic [31:0] trap_force;
      logic [31:0] chain_force;
      logic        chain_saturated;
      logic        last;
   } step_rsp_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;
   logic req_valid;
   logic req_stall;
   logic signed [NOISE_BITS-1:0] req_noise_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic [31:0] rsp_step_index;
   logic signed [31:0] rsp_trap_position;
   logic signed [31:0] rsp_pipette_position;
   logic signed [31:0] rsp_extension;
   logic signed [31:0] rsp_trap_force;
   logic signed [31:0] rsp_chain_force;
   logic rsp_chain_saturated;
   logic rsp_last;

   trapped_bead_wlc_langevin_step_unit uut (.*);

   // model state and register mirror
   longint unsigned reg_q [8];
   longint trap_q;
   longint pipette_q;
   logic [COUNT_BITS-1:0] count_q;

   step_rsp_type pending_steps[$];
   int errors;
   int cycles;
   bit quiet;          // no idling at all
   int hold_cycles;    // long response hold-off, counted by the receiver

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic longint sat32(longint v);
      if (v > IMAX) return IMAX;
      if (v < IMIN) return IMIN;
      return v;
   endfunction

   function automatic void model_reset();
      reg_q[CSR_DECAY]  = 1073741824;
      reg_q[CSR_DRIFT]  = 0;
      reg_q[CSR_NOISE]  = 0;
      reg_q[CSR_PULL]   = 0;
      reg_q[CSR_PREFAC] = 5387;
      reg_q[CSR_INVCON] = 12632470;
      reg_q[CSR_STIFF]  = 0;
      reg_q[CSR_LIMIT]  = 1966080;
      trap_q = 0;
      pipette_q = 0;
      count_q = '0;
   endfunction

   // one Euler-Maruyama step: returns the response and advances model state
   function automatic step_rsp_type langevin_step(logic signed [NOISE_BITS-1:0] nz);
      longint ext, frc, wlc, r32, s, nxt;
      longint unsigned u, w, term;
      bit clip, lst;
      step_rsp_type e;
      ext = sat32(pipette_q - trap_q);
      frc = sat32((longint'(reg_q[CSR_STIFF]) * trap_q) >>> 16);
      r32 = (ext * longint'(reg_q[CSR_INVCON])) >>> 16;
      clip = 1'b0;
      if (r32 >= ONE32) begin
         // extension at or past contour length
         clip = 1'b1;
         wlc = IMAX;
      end else begin
         u = longint'(ONE32 - r32);
         w = (64'd1 << 55) / u;
         // huge 1/(2(1-r)) caps the term silently
         term = (w >= 64'd4294967296) ? 64'd4294967296 : ((w * w) >> 32);
         s = longint'(term) + (r32 >>> 16) - 16384;
         if (s > ONE32) s = ONE32;
         if (s < -ONE32) s = -ONE32;
         wlc = sat32((longint'(reg_q[CSR_PREFAC]) * s) >>> 16);
      end
      lst = (frc >= longint'(reg_q[CSR_LIMIT]));
      e.step_index = count_q[31:0];
      e.trap_position = trap_q[31:0];
      e.pipette_position = pipette_q[31:0];
      e.extension = ext[31:0];
      e.trap_force = frc[31:0];
      e.chain_force = wlc[31:0];
      e.chain_saturated = clip;
      e.last = lst;
      if (lst) begin
         trap_q = 0;
         pipette_q = 0;
         count_q = '0;
      end else begin
         nxt = ((longint'(reg_q[CSR_DECAY]) * trap_q) >>> 30)
             + ((longint'(reg_q[CSR_DRIFT]) * wlc) >>> 16)
             + ((longint'(reg_q[CSR_NOISE]) * longint'(nz)) >>> NOISE_FRAC);
         trap_q = sat32(nxt);
         pipette_q = sat32(pipette_q + longint'(reg_q[CSR_PULL]));
         count_q = count_q + 1'b1;
      end
      return e;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h (t=%0t)", field, got, want, $realtime);
      errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      step_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_steps.size() == 0) begin
            $display("unexpected response (t=%0t)", $realtime);
            errors++;
         end else begin
            e = pending_steps.pop_front();
            if (rsp_step_index !== e.step_index)
               report_mismatch("step_index", rsp_step_index, e.step_index);
            if (rsp_trap_position !== e.trap_position)
               report_mismatch("trap_position", rsp_trap_position, e.trap_position);
            if (rsp_pipette_position !== e.pipette_position)
               report_mismatch("pipette_position", rsp_pipette_position, e.pipette_position);
            if (rsp_extension !== e.extension)
               report_mismatch("extension", rsp_extension, e.extension);
            if (rsp_trap_force !== e.trap_force)
               report_mismatch("trap_force", rsp_trap_force, e.trap_force);
            if (rsp_chain_force !== e.chain_force)
               report_mismatch("chain_force", rsp_chain_force, e.chain_force);
            if (rsp_chain_saturated !== e.chain_saturated)
               report_mismatch("chain_saturated", rsp_chain_saturated, e.chain_saturated);
            if (rsp_last !== e.last)
               report_mismatch("last", rsp_last, e.last);
         end
      end
   end

   // response side stall: long hold-off first, else random bursts
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall = 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 14) - 1;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // offer one request, predict at the accepting edge
   task automatic send_noise(logic signed [NOISE_BITS-1:0] nz);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_noise_sample = nz;
      do @(posedge clock); while (req_stall);
      pending_steps.push_back(langevin_step(nz));
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid = 1'b0;
      req_noise_sample = NOISE_BITS'($urandom);
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   // register write, only while idle; bit 31 is dropped on 31-bit registers
   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      reg_q[idx] = (idx == CSR_INVCON) ? longint'(value) : longint'(value & 32'h7FFF_FFFF);
      @(negedge clock);
      csr_write = 1'b0;
      csr_data = $urandom;
   endtask

   // set unit stiffness and a zero force limit, then clear state through a forced restart
   task automatic restart_chain();
      write_reg(CSR_STIFF, 32'h0001_0000);
      write_reg(CSR_LIMIT, 32'h0000_0000);
      send_noise(16'sd0);
      go_idle();
   endtask

   task automatic test_defaults();
      send_noise(16'sh7FFF);
      send_noise(-16'sh8000);
      send_noise(16'sd0);
      go_idle();
   endtask

   task automatic test_noise_extremes();
      write_reg(CSR_NOISE, 32'h7FFF_FFFF);
      write_reg(CSR_DECAY, 32'hFFFF_FFFF);
      send_noise(16'sh7FFF);
      send_noise(16'sh7FFF);
      send_noise(-16'sh8000);
      send_noise(-16'sh8000);
      send_noise(-16'sh8000);
      go_idle();
      write_reg(CSR_NOISE, 32'h0000_0000);
      write_reg(CSR_DECAY, 32'h0000_0000);
      send_noise(16'sd1);
      go_idle();
   endtask

   task automatic test_chain_clip();
      restart_chain();
      write_reg(CSR_LIMIT, 32'h7FFF_FFFF);
      write_reg(CSR_STIFF, 32'h0000_0000);
      write_reg(CSR_INVCON, 32'hFFFF_FFFF);
      write_reg(CSR_PULL, 32'h0002_0000);
      write_reg(CSR_PREFAC, 32'h0000_0000);
      send_noise(16'sd5);
      send_noise(16'sd5);   // past contour with zero prefactor
      go_idle();
      write_reg(CSR_PREFAC, 32'h7FFF_FFFF);
      send_noise(-16'sd7);
      go_idle();
   endtask

   task automatic test_chain_term_cap();
      restart_chain();
      write_reg(CSR_LIMIT, 32'h7FFF_FFFF);
      write_reg(CSR_STIFF, 32'h0000_0000);
      write_reg(CSR_PULL, 32'h0000_FFFF);
      write_reg(CSR_DRIFT, 32'h0000_0100);
      send_noise(16'sd0);
      send_noise(16'sd0);   // r just below one
      go_idle();
   endtask

   task automatic test_force_limit();
      restart_chain();
      write_reg(CSR_LIMIT, 32'h0000_8000);
      write_reg(CSR_PULL, 32'h0000_0000);
      write_reg(CSR_DRIFT, 32'h0000_0000);
      write_reg(CSR_DECAY, 32'h4000_0000);
      write_reg(CSR_NOISE, 32'h0000_4000);
      repeat (4) send_noise(16'sh1000);
      go_idle();
   endtask

   task automatic test_position_saturation();
      restart_chain();
      write_reg(CSR_LIMIT, 32'hFFFF_FFFF);
      write_reg(CSR_STIFF, 32'h7FFF_FFFF);
      write_reg(CSR_PULL, 32'hFFFF_FFFF);
      write_reg(CSR_NOISE, 32'h7FFF_FFFF);
      write_reg(CSR_DRIFT, 32'h7FFF_FFFF);
      send_noise(-16'sh8000);
      send_noise(16'sh7FFF);
      send_noise(16'sd0);
      go_idle();
   endtask

   // block fills up while the response side holds off
   task automatic test_backpressure();
      restart_chain();
      write_reg(CSR_LIMIT, 32'h0010_0000);
      write_reg(CSR_STIFF, 32'h0000_0800);
      hold_cycles = 600;
      repeat (8) send_noise(NOISE_BITS'($urandom));
      go_idle();
   endtask

   function automatic logic [31:0] random_reg_value(csr_idx_type idx);
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return (idx == CSR_DECAY) ? 32'h4000_0000 - $urandom_range(0, 1 << 24)
                                       : $urandom;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic test_random();
      int phase;
      for (phase = 0; phase < 12; phase++) begin
         quiet = (phase >= 10);
         restart_chain();
         for (int i = 0; i < 8; i++) write_reg(csr_idx_type'(i), random_reg_value(csr_idx_type'(i)));
         // mostly a working pulling setup so steps build up before a restart
         if (phase % 3 != 2) begin
            write_reg(CSR_DECAY, 32'h4000_0000 - $urandom_range(0, 1 << 26));
            write_reg(CSR_PULL, $urandom_range(0, 1 << 16));
            write_reg(CSR_STIFF, $urandom_range(0, 1 << 17));
         end
         repeat (100) send_noise(NOISE_BITS'($urandom));
         go_idle();
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      quiet = 1'b0;
      hold_cycles = 0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_DECAY;
      csr_data = '0;
      req_valid = 1'b0;
      req_noise_sample = '0;
      rsp_stall = 1'b0;
      model_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_defaults();
      test_noise_extremes();
      test_chain_clip();
      test_chain_term_cap();
      test_force_limit();
      test_position_saturation();
      test_backpressure();
      test_random();

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tbwlc_pkg.sv
rtl/tbwlc_ctrl.sv
rtl/tbwlc_datapath.sv
rtl/trapped_bead_wlc_langevin_step_unit.sv
sim/tb_top.sv
